FILE: rtl/srr_pkg.sv
package srr_pkg;

    // window and sequence space
    localparam int WINDOW       = 4;
    localparam int SEQ_SPACE    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_W  = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
    localparam int SLOT_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = SLOT_W;

    // stream data width: seq/ack number then payload, padded to bytes
    localparam int TDATA_W = ((SEQ_W + PAYLOAD_BITS + 7) / 8) * 8;

    // result kinds carried on tuser
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_DELIV = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DELIV
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic emit_ack;
        logic emit_deliv;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pkt_valid;
        logic start_deliv;
        logic deliv_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/selective_repeat_receiver.sv
// Channel  Dir  Handshake          Payload
// s        in   tvalid/tready      tdata: seq_num[2:0], payload[66:3]; tuser: checksum_ok
// m        out  tvalid/tready      tdata: ack_num[2:0], delivered_payload[66:3];
//                                  tuser: kind; tlast: last
//
// One packet at a time: the packet is taken, then its results are emitted
// in turn (ack, then up to WINDOW in-order deliveries). A dropped packet
// emits no result. The result count is set by the delivery sequencer
// walking the buffer one slot per cycle unless the output stalls.
// Reset: synchronous, active low; base returns to 1, buffer marked empty.
// Output stalls hold the sequencer; input is taken only when idle.
module selective_repeat_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [srr_pkg::TDATA_W-1:0] i_s_tdata,  // seq_num, payload, zero pad
    input  logic                        i_s_tuser,  // checksum_ok
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [srr_pkg::TDATA_W-1:0] o_m_tdata,  // ack_num, delivered_payload, zero pad
    output logic                        o_m_tuser,  // kind
    output logic                        o_m_tlast
);

    srr_pkg::t_cmd    cmd;
    srr_pkg::t_status status;

    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    srr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/srr_ctrl.sv
module srr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  srr_pkg::t_status i_status,
    output srr_pkg::t_cmd    o_cmd
);

    srr_pkg::t_state r_state;
    srr_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_s_tready       = 1'b0;
        case (r_state)
            srr_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = srr_pkg::ST_EVAL;
                end
            end
            srr_pkg::ST_EVAL: begin
                // corrupt or out-of-window packets are dropped silently
                if (!i_status.pkt_valid) begin
                    n_state = srr_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state = i_status.start_deliv ? srr_pkg::ST_DELIV : srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_DELIV: begin
                if (i_status.out_free) begin
                    o_cmd.emit_deliv = 1'b1;
                    if (i_status.deliv_last) begin
                        n_state = srr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/srr_dp.sv
module srr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srr_pkg::t_cmd               i_cmd,
    output srr_pkg::t_status            o_status,
    input  logic [srr_pkg::TDATA_W-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [srr_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int SW = srr_pkg::SEQ_W;
    localparam int LW = srr_pkg::SLOT_W;
    localparam int PW = srr_pkg::PAYLOAD_BITS;

    // latched packet
    logic          r_ok;
    logic [SW-1:0] r_seq;
    logic [PW-1:0] r_pay;

    // window state
    logic [SW-1:0]             r_base;
    logic [LW-1:0]             r_head;
    logic [srr_pkg::WINDOW-1:0] r_flags;
    logic [srr_pkg::CNT_W-1:0] r_cnt;
    logic [PW-1:0]             r_store [srr_pkg::WINDOW];

    // output register
    logic                        r_m_valid;
    logic                        r_m_kind;
    logic                        r_m_last;
    logic [srr_pkg::TDATA_W-1:0] r_m_data;

    logic [SW:0]   diff;
    logic [SW-1:0] off;
    logic          in_rcv;
    logic          in_prev;
    logic [LW:0]   slot_sum;
    logic [LW-1:0] slot;
    logic [LW:0]   head_sum;
    logic [LW-1:0] head_nx;
    logic [SW-1:0] base_nx;
    logic          out_free;

    // offset of the packet from the window base, modulo the sequence space
    always_comb begin
        diff = {1'b0, r_seq} + (SW+1)'(srr_pkg::SEQ_SPACE) - {1'b0, r_base};
        if (diff >= (SW+1)'(srr_pkg::SEQ_SPACE)) begin
            off = SW'(diff - (SW+1)'(srr_pkg::SEQ_SPACE));
        end else begin
            off = SW'(diff);
        end
        in_rcv  = 32'(off) < srr_pkg::WINDOW;
        in_prev = (srr_pkg::WINDOW >= srr_pkg::SEQ_SPACE) ||
                  (32'(off) >= srr_pkg::SEQ_SPACE - srr_pkg::WINDOW);
    end

    // buffer slot of the packet (meaningful only inside the window)
    always_comb begin
        slot_sum = {1'b0, r_head} + (LW+1)'(off[LW-1:0]);
        if (slot_sum >= (LW+1)'(srr_pkg::WINDOW)) begin
            slot = LW'(slot_sum - (LW+1)'(srr_pkg::WINDOW));
        end else begin
            slot = LW'(slot_sum);
        end
        head_sum = {1'b0, r_head} + (LW+1)'(1);
        if (head_sum >= (LW+1)'(srr_pkg::WINDOW)) begin
            head_nx = '0;
        end else begin
            head_nx = LW'(head_sum);
        end
        if (32'(r_base) == srr_pkg::SEQ_SPACE - 1) begin
            base_nx = '0;
        end else begin
            base_nx = r_base + SW'(1);
        end
    end

    assign out_free = !r_m_valid || i_m_tready;

    // status
    always_comb begin
        o_status.pkt_valid   = r_ok && (in_rcv || in_prev);
        o_status.start_deliv = in_rcv && (off == '0);
        o_status.deliv_last  = (32'(r_cnt) == srr_pkg::WINDOW - 1) || !r_flags[head_nx];
        o_status.out_free    = out_free;
    end

    // packet capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else if (i_cmd.latch_in) begin
            r_ok <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_seq <= i_s_tdata[SW-1:0];
            r_pay <= i_s_tdata[SW +: PW];
        end
    end

    // window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= SW'(1 % srr_pkg::SEQ_SPACE);
            r_head  <= '0;
            r_flags <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.emit_ack) begin
            r_cnt <= '0;
            if (in_rcv) begin
                r_flags[slot] <= 1'b1;
            end
        end else if (i_cmd.emit_deliv) begin
            r_flags[r_head] <= 1'b0;
            r_head          <= head_nx;
            r_base          <= base_nx;
            r_cnt           <= r_cnt + srr_pkg::CNT_W'(1);
        end
    end

    // payload buffer, first copy kept
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ack && in_rcv && !r_flags[slot]) begin
            r_store[slot] <= r_pay;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit_ack || i_cmd.emit_deliv) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ack) begin
            r_m_kind <= srr_pkg::KIND_ACK;
            r_m_last <= !(in_rcv && (off == '0));
            r_m_data <= srr_pkg::TDATA_W'(r_seq);
        end else if (i_cmd.emit_deliv) begin
            r_m_kind <= srr_pkg::KIND_DELIV;
            r_m_last <= o_status.deliv_last;
            r_m_data <= srr_pkg::TDATA_W'({r_store[r_head], {SW{1'b0}}});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

endmodule
